>>> sv/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg: shared types and constants of the tile line renderer
// Memory geometry, screen size, operation and register codes, pixel helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tlr_pkg;

    // Video memory geometry; MEM_WORDS must be a power of two (address wrap
    // is done by dropping the upper address bits).
    localparam int MEM_WORDS = 65536;
    localparam int ADDR_W    = $clog2(MEM_WORDS);

    // Screen size in cells
    localparam int CELL_COLS = 32;
    localparam int CELL_ROWS = 24;

    // Full-width address arithmetic before the wrap
    localparam int SRC_W = 17;

    localparam logic [7:0]       RAM_CODE_FIRST = 8'hE0;
    localparam logic [4:0]       RAM_CODE_MASK  = 5'h1F;
    localparam logic [SRC_W-1:0] RAM_OFFSET     = 17'h00400;

    localparam int NUM_PIXELS = 8;
    localparam int PIX_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = NUM_PIXELS * PIX_W;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_RENDER = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_VRAM_PAGE    = 3'd0,
        REG_PATTERN_PAGE = 3'd1,
        REG_PLANE1_COLOR = 3'd2,
        REG_PLANE2_COLOR = 3'd3,
        REG_PLANE3_COLOR = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,    // waiting for a transaction
        ST_CODE,    // cell code on the read port
        ST_PLANE1,  // plane 1 byte on the read port
        ST_PLANE2,  // plane 2 byte on the read port
        ST_PLANE3,  // plane 3 byte on the read port, result ready
        ST_HOLD     // result parked until the output register frees up
    } state_t;

    // Element i is pixel_i, occupying bits [3i+2:3i]
    typedef logic [NUM_PIXELS-1:0][PIX_W-1:0] pix_vec_t;

    // OR a plane color into every pixel whose pattern bit is set (MSB first)
    function automatic pix_vec_t plane_or(input pix_vec_t acc,
                                          input logic [7:0] bits,
                                          input logic [PIX_W-1:0] color);
        pix_vec_t res;
        res = acc;
        for (int i = 0; i < NUM_PIXELS; i++)
        begin
            if (bits[NUM_PIXELS-1-i])
            begin
                res[i] = acc[i] | color;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/tile_line_renderer.sv
// ----------------------------------------------------------------------------
// tile_line_renderer: one pixel line of one 8x8 character cell
// Byte-wide video memory filled by write transactions; render transactions
// fetch the cell code and three pattern planes and return eight pixels.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  --------  ---------  --------------------------  -----------------------------
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser: operation
//                                                    tdata: address, data, cell
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: pixel_0 .. pixel_7
//  cfg       in         cfg_we (no wait)             cfg_index, cfg_data
//
//  A render does one name-table read and three plane reads, serialized on
//  the single memory port. After a render, the next transaction is
//  accepted only as its result is loaded into the output register.
//  An off-screen cell reads no memory and yields all-zero pixels.
//  Reset clears control state and the page registers and sets the plane
//  colors to 1, 2 and 4; the memory content is undefined until written.
//  A stalled m_axis parks one finished result.
//
`default_nettype none

module tile_line_renderer
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // cfg
    input  wire logic                             cfg_we,
    input  wire logic [tlr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tlr_pkg::CFG_DATA_W-1:0]   cfg_data,

    // input stream
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    // [15:0] mem_address, [23:16] mem_data, [28:24] cell_col,
    // [33:29] cell_row, [36:34] pixel_line, [39:37] zero
    input  wire logic [tlr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] operation
    input  wire logic                             s_axis_tuser,

    // output stream
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [2:0] pixel_0, [5:3] pixel_1, ... [23:21] pixel_7
    output      logic [tlr_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    import tlr_pkg::*;

    // ------------------------------------------------------------------
    // Input field decode
    // ------------------------------------------------------------------
    logic [15:0] in_mem_address;
    logic [7:0]  in_mem_data;
    logic [4:0]  in_col;
    logic [4:0]  in_row;
    logic [2:0]  in_line;
    logic        in_acc;
    logic        in_render;
    logic        in_onscreen;

    assign in_mem_address = s_axis_tdata[15:0];
    assign in_mem_data    = s_axis_tdata[23:16];
    assign in_col         = s_axis_tdata[28:24];
    assign in_row         = s_axis_tdata[33:29];
    assign in_line        = s_axis_tdata[36:34];

    assign in_acc      = s_axis_tvalid && s_axis_tready;
    assign in_render   = (op_t'(s_axis_tuser) == OP_RENDER);
    assign in_onscreen = ({1'b0, in_col} < 6'(CELL_COLS)) &&
                         ({1'b0, in_row} < 6'(CELL_ROWS));

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]       vram_page_reg;
    logic [7:0]       pattern_page_reg;
    logic [PIX_W-1:0] plane1_color_reg;
    logic [PIX_W-1:0] plane2_color_reg;
    logic [PIX_W-1:0] plane3_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vram_page_reg    <= 8'd0;
            pattern_page_reg <= 8'd0;
            plane1_color_reg <= 3'd1;
            plane2_color_reg <= 3'd2;
            plane3_color_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VRAM_PAGE:    vram_page_reg    <= cfg_data;
                REG_PATTERN_PAGE: pattern_page_reg <= cfg_data;
                REG_PLANE1_COLOR: plane1_color_reg <= cfg_data[PIX_W-1:0];
                REG_PLANE2_COLOR: plane2_color_reg <= cfg_data[PIX_W-1:0];
                REG_PLANE3_COLOR: plane3_color_reg <= cfg_data[PIX_W-1:0];
                default:          ;  // unknown index: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Video memory: single port, registered read
    // ------------------------------------------------------------------
    logic [7:0]        vram_mem [MEM_WORDS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vram_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= vram_mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    state_t           state_reg, state_next;
    logic [SRC_W-1:0] src_reg, src_next;
    logic [2:0]       line_reg, line_next;
    pix_vec_t         acc_reg, acc_next;
    logic             m_valid_reg, m_valid_next;
    pix_vec_t         m_data_reg, m_data_next;

    logic             out_free;
    logic             out_load;
    pix_vec_t         pix_final;
    logic [SRC_W-1:0] name_addr;
    logic [SRC_W-1:0] code_src;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign pix_final = plane_or(acc_reg, rd_data_reg, plane3_color_reg);

    // name table: page*256 + row*32 + col
    assign name_addr = SRC_W'({vram_page_reg, 8'h00}) + SRC_W'({in_row, in_col});

    // pattern base from the cell code on the read port
    always_comb
    begin
        if (rd_data_reg < RAM_CODE_FIRST)
        begin
            code_src = SRC_W'({pattern_page_reg, 8'h00}) +
                       SRC_W'({rd_data_reg, 5'b00000});
        end
        else
        begin
            code_src = SRC_W'({vram_page_reg, 8'h00}) + RAM_OFFSET +
                       SRC_W'({rd_data_reg[4:0] & RAM_CODE_MASK, 5'b00000});
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   state_next = ST_IDLE;
            ST_CODE:   state_next = ST_PLANE1;
            ST_PLANE1: state_next = ST_PLANE2;
            ST_PLANE2: state_next = ST_PLANE3;
            ST_PLANE3: state_next = out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD:   state_next = out_free ? ST_IDLE : ST_HOLD;
            default:   state_next = ST_IDLE;
        endcase
        if (in_acc)
        begin
            if (!in_render)
            begin
                state_next = ST_IDLE;
            end
            else if (in_onscreen)
            begin
                state_next = ST_CODE;
            end
            else
            begin
                state_next = ST_HOLD;  // zero result, no memory reads
            end
        end
    end

    // outputs: handshake and output register load, from state and out_free
    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_PLANE3, ST_HOLD:
            begin
                s_axis_tready = out_free;
                out_load      = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase

        m_valid_next = out_load ? 1'b1 : (m_valid_reg && !m_axis_tready);
    end

    // outputs: memory port and datapath
    always_comb
    begin
        mem_we        = 1'b0;
        mem_wdata     = in_mem_data;
        mem_addr      = name_addr[ADDR_W-1:0];
        src_next      = src_reg;
        line_next     = line_reg;
        acc_next      = acc_reg;
        m_data_next   = m_data_reg;

        case (state_reg)
            ST_CODE:
            begin
                src_next = code_src;
                mem_addr = ADDR_W'(code_src + SRC_W'({2'd1, line_reg}));
                acc_next = '0;
            end
            ST_PLANE1:
            begin
                mem_addr = ADDR_W'(src_reg + SRC_W'({2'd2, line_reg}));
                acc_next = plane_or(acc_reg, rd_data_reg, plane1_color_reg);
            end
            ST_PLANE2:
            begin
                mem_addr = ADDR_W'(src_reg + SRC_W'({2'd3, line_reg}));
                acc_next = plane_or(acc_reg, rd_data_reg, plane2_color_reg);
            end
            ST_PLANE3:
            begin
                acc_next      = pix_final;
                m_data_next   = out_free ? pix_final : m_data_reg;
            end
            ST_HOLD:
            begin
                m_data_next   = out_free ? acc_reg : m_data_reg;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase

        if (in_acc)
        begin
            if (!in_render)
            begin
                mem_we   = 1'b1;
                mem_addr = in_mem_address[ADDR_W-1:0];
            end
            else
            begin
                mem_addr  = name_addr[ADDR_W-1:0];
                line_next = in_line;
                acc_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg    <= src_next;
        line_reg   <= line_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (in_acc && !in_render))
        else $error("memory written outside a write transaction");

    a_fetch_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CODE) |=> (state_reg == ST_PLANE1) ##1
            (state_reg == ST_PLANE2) ##1 (state_reg == ST_PLANE3))
        else $error("plane fetch sequence broken");

    a_code_after_render: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CODE) |-> $past(in_acc && in_render && in_onscreen))
        else $error("name fetch without an on-screen render");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !$past(m_valid_reg && !m_axis_tready)) |->
            ($past(state_reg) == ST_PLANE3 || $past(state_reg) == ST_HOLD))
        else $error("result produced without a finished render");

endmodule

`default_nettype wire

>>> tb/tile_line_renderer_checker.sv
// ----------------------------------------------------------------------------
// tile_line_renderer_checker: scoreboard for the tile line renderer
// Mirrors config writes and memory-write transactions, predicts the pixel line
// of every render transaction and compares it with the m_axis output in order.
// ----------------------------------------------------------------------------

module tile_line_renderer_checker
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_we,
    input  logic [tlr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlr_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [tlr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                             s_axis_tuser,

    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [tlr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,

    output int                               fail_count,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 200;

    logic [7:0]        vid_mem [0:tlr_pkg::MEM_WORDS-1];
    logic [7:0]        vram_page;
    logic [7:0]        pattern_page;
    logic [2:0]        plane_color [1:3];
    tlr_pkg::pix_vec_t pending_lines [$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    // One line of one cell; off-screen cells read nothing and stay black.
    function automatic tlr_pkg::pix_vec_t render_cell_line(input logic [4:0] col,
                                                           input logic [4:0] row,
                                                           input logic [2:0] line);
        tlr_pkg::pix_vec_t px;
        logic [16:0]       addr;
        logic [16:0]       src;
        logic [7:0]        code;
        logic [7:0]        bits;
        px = '0;
        if (col < tlr_pkg::CELL_COLS && row < tlr_pkg::CELL_ROWS)
        begin
            addr = {vram_page, 8'h00} + {row, 5'h00} + col;
            code = vid_mem[addr[tlr_pkg::ADDR_W-1:0]];
            if (code < tlr_pkg::RAM_CODE_FIRST)
            begin
                src = {pattern_page, 8'h00} + {code, 5'h00};
            end
            else
            begin
                src = {vram_page, 8'h00} + tlr_pkg::RAM_OFFSET
                    + {code[4:0] & tlr_pkg::RAM_CODE_MASK, 5'h00};
            end
            for (int p = 1; p <= 3; p++)
            begin
                addr = src + 17'(p * 8) + line;
                bits = vid_mem[addr[tlr_pkg::ADDR_W-1:0]];
                for (int i = 0; i < tlr_pkg::NUM_PIXELS; i++)
                begin
                    if (bits[tlr_pkg::NUM_PIXELS-1-i])
                    begin
                        px[i] = px[i] | plane_color[p];
                    end
                end
            end
        end
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        tlr_pkg::pix_vec_t got;
        tlr_pkg::pix_vec_t want;
        if (!rst_n)
        begin
            vram_page      = '0;
            pattern_page   = '0;
            plane_color[1] = 3'd1;
            plane_color[2] = 3'd2;
            plane_color[3] = 3'd4;
            pending_lines.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (tlr_pkg::reg_idx_t'(cfg_index))
                    tlr_pkg::REG_VRAM_PAGE:    vram_page      = cfg_data;
                    tlr_pkg::REG_PATTERN_PAGE: pattern_page   = cfg_data;
                    tlr_pkg::REG_PLANE1_COLOR: plane_color[1] = cfg_data[2:0];
                    tlr_pkg::REG_PLANE2_COLOR: plane_color[2] = cfg_data[2:0];
                    tlr_pkg::REG_PLANE3_COLOR: plane_color[3] = cfg_data[2:0];
                    default: ;
                endcase
            end

            // output first, so a same-edge input cannot mask a spurious result
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (pending_lines.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("%0t: result with nothing expected, expected none actual %h",
                                 $time, m_axis_tdata);
                    end
                end
                else
                begin
                    want = pending_lines.pop_front();
                    for (int i = 0; i < tlr_pkg::NUM_PIXELS; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            fail_count++;
                            if (fail_count <= MAX_REPORTS)
                            begin
                                $display("%0t: pixel_%0d expected %0d actual %0d",
                                         $time, i, want[i], got[i]);
                            end
                        end
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (tlr_pkg::op_t'(s_axis_tuser) == tlr_pkg::OP_WRITE)
                begin
                    vid_mem[s_axis_tdata[15:0]] = s_axis_tdata[23:16];
                end
                else
                begin
                    pending_lines.push_back(render_cell_line(s_axis_tdata[28:24],
                                                             s_axis_tdata[33:29],
                                                             s_axis_tdata[36:34]));
                end
            end
        end
        outstanding = pending_lines.size();
    end

endmodule

>>> tb/tile_line_renderer_tb.sv
// ----------------------------------------------------------------------------
// tile_line_renderer_tb: testbench top for the tile line renderer
// Drives memory-write and render transactions with random gaps and output
// stalls through several config settings; the checker scores every line.
// ----------------------------------------------------------------------------

module tile_line_renderer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlr_pkg::*;

    localparam int          RANDOM_ITEMS = 1800;
    localparam int          NUM_PHASES   = 6;
    localparam int          DRAIN_CYCLES = 8;     // covers a render plus a parked result
    localparam int          LONG_HOLD    = 300;   // receiver hold-off, in cycles
    localparam int          HOLD_BURST   = 40;    // renders offered during the hold
    localparam int unsigned LIMIT_CYCLES = 1000000;

    // ------------------------------------------------------------------------
    // DUT inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;
    logic                    s_axis_tvalid = 1'b0;
    // [15:0] mem_address, [23:16] mem_data, [28:24] cell_col,
    // [33:29] cell_row, [36:34] pixel_line, [39:37] zero
    logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
    // [0] operation
    logic                    s_axis_tuser  = 1'b0;
    logic                    m_axis_tready = 1'b0;

    logic                    s_axis_tready;
    logic                    m_axis_tvalid;
    // [2:0] pixel_0, [5:3] pixel_1, ... [23:21] pixel_7
    logic [OUT_DATA_W-1:0]   m_axis_tdata;

    int fail_count;
    int outstanding;

    // ------------------------------------------------------------------------
    // Stimulus-side view of memory: which bytes hold known data, so that no
    // render ever reads a byte that was never written.
    // ------------------------------------------------------------------------
    logic [7:0] known_mem [0:MEM_WORDS-1];
    bit         known_set [0:MEM_WORDS-1];
    logic [7:0] cur_vram_page    = '0;
    logic [7:0] cur_pattern_page = '0;

    int n_sent       = 0;   // accepted input transactions
    bit no_idle      = 1'b0; // both sides run without gaps
    int holds_asked  = 0;
    int holds_given  = 0;

    tile_line_renderer u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tile_line_renderer_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Mostly no gap, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)      return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else             return $urandom_range(20, 60);
    endfunction

    // Cell codes lean toward the boundary between pattern set and char RAM.
    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)     return RAM_CODE_FIRST - 8'd1;
        else if (r == 1) return RAM_CODE_FIRST;
        else if (r < 5) return 8'($urandom_range(RAM_CODE_FIRST, 255));
        else            return 8'($urandom_range(0, RAM_CODE_FIRST - 1));
    endfunction

    function automatic logic [15:0] name_addr(input logic [4:0] col, input logic [4:0] row);
        logic [16:0] a;
        a = {cur_vram_page, 8'h00} + {row, 5'h00} + col;
        return a[15:0];
    endfunction

    // Address of one plane byte for a given code; wraps like the memory does.
    function automatic logic [15:0] plane_addr(input logic [7:0] code, input int plane,
                                               input logic [2:0] line);
        logic [16:0] a;
        if (code < RAM_CODE_FIRST)
        begin
            a = {cur_pattern_page, 8'h00} + {code, 5'h00};
        end
        else
        begin
            a = {cur_vram_page, 8'h00} + RAM_OFFSET + {code[4:0], 5'h00};
        end
        a = a + 17'(plane * 8) + line;
        return a[15:0];
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one transaction, then a random gap. tvalid stays high across
    // back-to-back transactions, so it is only lowered when a gap follows.
    // ------------------------------------------------------------------------
    task automatic push_item(input op_t op, input logic [15:0] addr, input logic [7:0] data,
                             input logic [4:0] col, input logic [4:0] row,
                             input logic [2:0] line);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, line, row, col, data, addr};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        if (op == OP_WRITE)
        begin
            known_mem[addr] = data;
            known_set[addr] = 1'b1;
        end
        n_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // cell fields of a write are don't-care, so they carry random bits
    task automatic mem_write(input logic [15:0] addr, input logic [7:0] data);
        push_item(OP_WRITE, addr, data, 5'($urandom), 5'($urandom), 3'($urandom));
    endtask

    // Render one line, first writing whatever it would read that is still
    // unknown. A plane byte may land on the code byte itself, so loop until a
    // pass writes nothing.
    task automatic render_line(input logic [4:0] col, input logic [4:0] row,
                               input logic [2:0] line);
        bit          wrote;
        logic [15:0] a;
        if (col < CELL_COLS && row < CELL_ROWS)
        begin
            do
            begin
                wrote = 1'b0;
                a = name_addr(col, row);
                if (!known_set[a])
                begin
                    mem_write(a, pick_code());
                    wrote = 1'b1;
                end
                for (int p = 1; p <= 3; p++)
                begin
                    a = plane_addr(known_mem[name_addr(col, row)], p, line);
                    if (!known_set[a])
                    begin
                        mem_write(a, 8'($urandom));
                        wrote = 1'b1;
                    end
                end
            end
            while (wrote);
        end
        push_item(OP_RENDER, 16'($urandom), 8'($urandom), col, row, line);
    endtask

    // Well-formed sequence: set a cell code, its three plane bytes, render.
    task automatic paint_cell(input logic [4:0] col, input logic [4:0] row,
                              input logic [2:0] line, input logic [7:0] code,
                              input logic [7:0] p1, input logic [7:0] p2,
                              input logic [7:0] p3);
        mem_write(name_addr(col, row), code);
        mem_write(plane_addr(code, 1, line), p1);
        mem_write(plane_addr(code, 2, line), p2);
        mem_write(plane_addr(code, 3, line), p3);
        render_line(col, row, line);
    endtask

    // cfg_we is left high; the caller lowers it after the last write
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Color writes carry random upper bits, which the block must drop.
    task automatic apply_config(input logic [7:0] vp, input logic [7:0] pp,
                                input logic [2:0] c1, input logic [2:0] c2,
                                input logic [2:0] c3);
        cfg_put(REG_VRAM_PAGE, vp);
        cfg_put(REG_PATTERN_PAGE, pp);
        cfg_put(REG_PLANE1_COLOR, {5'($urandom), c1});
        cfg_put(REG_PLANE2_COLOR, {5'($urandom), c2});
        cfg_put(REG_PLANE3_COLOR, {5'($urandom), c3});
        cfg_we <= 1'b0;
        cur_vram_page    = vp;
        cur_pattern_page = pp;
    endtask

    // Stop offering, wait for every expected line, then let a trailing
    // write settle before anything touches the config.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, plus the long hold-off on request. The
    // hold is counted here so the sender keeps pushing into a full block.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int g;
        stall_left = 0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (holds_given < holds_asked)
            begin
                holds_given++;
                stall_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                g = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
                if (g > 0)
                begin
                    stall_left = g - 1;
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
        $display("tile_line_renderer verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int r;
        int rand_base;
        int goal;
        logic [4:0] col;
        logic [4:0] row;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Indexes past the last register must leave the config alone; the
        // directed lines below still use the reset colors and pages.
        for (int k = REG_PLANE3_COLOR + 1; k < (1 << CFG_IDX_W); k++)
        begin
            cfg_put(CFG_IDX_W'(k), 8'hFF);
        end
        cfg_we <= 1'b0;

        // Off-screen cells, with every ignored field at its extremes
        push_item(OP_RENDER, 16'hFFFF, 8'hFF, 5'd31, 5'd31, 3'd7);
        push_item(OP_RENDER, 16'h0000, 8'h00, 5'd0, 5'(CELL_ROWS), 3'd0);
        // Writes at both ends of the address space
        push_item(OP_WRITE, 16'hFFFF, 8'hFF, 5'd31, 5'd31, 3'd7);
        push_item(OP_WRITE, 16'h0000, 8'h00, 5'd0, 5'd0, 3'd0);
        // Last pattern-set code, first and last char RAM codes, all-clear
        paint_cell(5'd31, 5'(CELL_ROWS - 1), 3'd7, RAM_CODE_FIRST - 8'd1,
                   8'hFF, 8'h00, 8'hAA);
        paint_cell(5'd0, 5'd0, 3'd0, RAM_CODE_FIRST, 8'h80, 8'h01, 8'h55);
        paint_cell(5'd5, 5'd3, 3'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        paint_cell(5'd17, 5'd12, 3'd2, 8'h00, 8'h00, 8'h00, 8'h00);

        rand_base = n_sent;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // sender waits for every expected line before the config moves
            drain_results();
            case (ph)
                0: apply_config(8'h00, 8'h00, 3'd1, 3'd2, 3'd4);
                // top pages: name table, patterns and char RAM all wrap
                1: apply_config(8'hFF, 8'hFF, 3'd7, 3'd7, 3'd7);
                2: apply_config(8'hFE, 8'h01, 3'd0, 3'd0, 3'd0);
                3: apply_config(8'h80, 8'hE0, 3'd3, 3'd5, 3'd6);
                default: apply_config(8'($urandom), 8'($urandom), 3'($urandom),
                                      3'($urandom), 3'($urandom));
            endcase
            no_idle = (ph == 2);

            if (ph == 3)
            begin
                // long output hold while the sender keeps offering renders
                no_idle = 1'b1;
                holds_asked++;
                repeat (HOLD_BURST)
                begin
                    render_line(5'($urandom), 5'($urandom_range(0, CELL_ROWS - 1)),
                                3'($urandom));
                end
                no_idle = 1'b0;
            end

            goal = rand_base + (ph + 1) * RANDOM_ITEMS / NUM_PHASES;
            while (n_sent < goal)
            begin
                r   = $urandom_range(0, 99);
                col = 5'($urandom);
                row = 5'($urandom_range(0, CELL_ROWS - 1));
                if (r < 45)
                begin
                    render_line(col, row, 3'($urandom));
                end
                else if (r < 60)
                begin
                    paint_cell(col, row, 3'($urandom), pick_code(), 8'($urandom),
                               8'($urandom), 8'($urandom));
                end
                else if (r < 67)
                begin
                    render_line(col, 5'($urandom_range(CELL_ROWS, 31)), 3'($urandom));
                end
                else if (r < 80)
                begin
                    // recode a cell already on screen
                    mem_write(name_addr(col, row), pick_code());
                end
                else if (r < 90)
                begin
                    // touch a pattern byte of a random code
                    mem_write(plane_addr(pick_code(), $urandom_range(1, 3), 3'($urandom)),
                              8'($urandom));
                end
                else
                begin
                    mem_write(16'($urandom), 8'($urandom));
                end
            end
        end

        drain_results();
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("tile_line_renderer verification clean");
        end
        else
        begin
            $display("tile_line_renderer verification failed");
        end
        $finish;
    end

endmodule
